### rtl/core/vmrd_pkg.sv
// Package for the request dispatcher: sizes, register indexes, policy codes.
// No dependencies.
package vmrd_pkg;
    localparam int LAYERS      = 4;
    localparam int NODES       = 16;
    localparam int COUNT_WIDTH = 8;
    localparam int LW = $clog2(LAYERS);
    localparam int NW = $clog2(NODES);
    localparam int NCW = $clog2(NODES + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAXREQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NODES0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NODES1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NODES2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NODES3 = 3'd5;

    localparam logic [1:0] POL_UNSET = 2'd0;
    localparam logic [1:0] POL_FIRST = 2'd1;
    localparam logic [1:0] POL_RR    = 2'd2;
    localparam logic [1:0] POL_LEAST = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                   valid;
        logic                   found;
        logic [NW-1:0]          id;
        logic [COUNT_WIDTH-1:0] best;
    } t_scan;

    typedef struct packed {
        logic                   valid;
        logic [LW-1:0]          layer;
        logic [NW-1:0]          srv;
        logic [COUNT_WIDTH-1:0] cnt;
    } t_wr;
endpackage

### rtl/core/vmrd_if.sv
// Valid/ready channel carrying one item of type T.
// Depends on nothing.
interface vmrd_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/vm_request_dispatcher_unit.sv
// Request dispatcher top: config registers, control FSM and a chain of
// NODES server cells. Depends on vmrd_pkg, vmrd_if, vmrd_cell.
// A write item is stored in the addressed cell on acceptance. A select item
// is launched in the cycle after acceptance, then travels the chain of NODES
// cells, one register per cell, and lands in the output register; one item is
// in flight at a time. The result sits in an output register and the next
// item is accepted once it is taken.
module vm_request_dispatcher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            cfg_we,
    input  logic [vmrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vmrd_pkg::CFG_DATA_W-1:0] cfg_data,
    vmrd_if.sink                            in_ch,
    vmrd_if.source                          out_ch
);
    import vmrd_pkg::*;

    logic [1:0]     r_policy;
    logic [7:0]     r_max;
    logic [4:0]     r_nodes [4];
    logic [NW-1:0]  r_ptr [LAYERS];
    logic [LW-1:0]  r_layer;
    logic [NW-1:0]  r_start;
    logic [NCW-1:0] r_n;
    logic           r_go;
    t_state         r_state, n_state;
    logic           r_res_found;
    logic [NW-1:0]  r_res_id;
    t_scan          w_chain [NODES+1];
    t_wr            w_wr;
    logic [4:0]     w_nraw;
    logic [NCW-1:0] w_n;
    logic           w_acc;
    logic           w_sel;
    logic [NW-1:0]  w_next;

    assign w_acc  = in_ch.valid && in_ch.ready;
    assign w_sel  = w_acc && in_ch.data[0];
    assign w_nraw = r_nodes[in_ch.data[2:1]];
    assign w_n    = (w_nraw > 5'(NODES)) ? NCW'(NODES) : NCW'(w_nraw);

    assign w_wr.valid = w_acc && !in_ch.data[0];
    assign w_wr.layer = in_ch.data[2:1];
    assign w_wr.srv   = in_ch.data[6:3];
    assign w_wr.cnt   = in_ch.data[14:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LEAST;
            r_max    <= 8'd255;
            for (int l = 0; l < 4; l++) r_nodes[l] <= 5'd16;
        end else if (cfg_we) begin
            if (cfg_index == REG_POLICY)      r_policy <= cfg_data[1:0];
            else if (cfg_index == REG_MAXREQ) r_max <= cfg_data;
            else if (cfg_index >= REG_NODES0 && cfg_index <= REG_NODES3)
                r_nodes[2'(cfg_index - REG_NODES0)] <= cfg_data[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_go <= 1'b0;
        else          r_go <= w_sel;
    end

    assign w_chain[0].valid = r_go;
    assign w_chain[0].found = 1'b0;
    assign w_chain[0].id    = '0;
    assign w_chain[0].best  = '0;

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        vmrd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (NW'(g)),
            .i_wr     (w_wr),
            .i_layer  (r_layer),
            .i_policy (r_policy),
            .i_max    (r_max),
            .i_start  (r_start),
            .i_n      (r_n),
            .i_scan   (w_chain[g]),
            .o_scan   (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_layer <= in_ch.data[2:1];
            r_n     <= w_n;
            r_start <= ({1'b0, r_ptr[in_ch.data[2:1]]} >= w_n) ? '0
                       : r_ptr[in_ch.data[2:1]];
        end
    end

    assign w_next = ({1'b0, w_chain[NODES].id} + 1'b1 == r_n) ? '0
                    : w_chain[NODES].id + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LAYERS; l++) r_ptr[l] <= '0;
        end else if (w_chain[NODES].valid && w_chain[NODES].found
                     && r_policy == POL_RR) begin
            r_ptr[r_layer] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chain[NODES].valid) begin
            r_res_found <= w_chain[NODES].found;
            r_res_id    <= w_chain[NODES].found ? w_chain[NODES].id : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_sel) n_state = ST_SCAN;
            ST_SCAN: if (w_chain[NODES].valid) n_state = ST_OUT;
            ST_OUT:  if (out_ch.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ch.ready  = (r_state == ST_IDLE);
        out_ch.valid = (r_state == ST_OUT);
        out_ch.data  = {r_res_id, !r_res_found};
    end

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sel |=> !in_ch.ready) else $error("item accepted during scan");
    a_chain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[NODES].valid |-> r_state == ST_SCAN) else $error("stray scan");
    a_sat_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !r_res_found |-> r_res_id == '0) else $error("bad id");
endmodule

### rtl/core/vmrd_cell.sv
// One server cell: holds a count per layer and folds it into the passing scan.
// Depends on vmrd_pkg.
module vmrd_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [vmrd_pkg::NW-1:0]       i_index,
    input  vmrd_pkg::t_wr                 i_wr,
    input  logic [vmrd_pkg::LW-1:0]       i_layer,
    input  logic [1:0]                    i_policy,
    input  logic [7:0]                    i_max,
    input  logic [vmrd_pkg::NW-1:0]       i_start,
    input  logic [vmrd_pkg::NCW-1:0]      i_n,
    input  vmrd_pkg::t_scan               i_scan,
    output vmrd_pkg::t_scan               o_scan
);
    import vmrd_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt [LAYERS];
    logic                   w_cand;
    logic                   w_take;
    t_scan                  n_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LAYERS; l++) r_cnt[l] <= '0;
        end else if (i_wr.valid && i_wr.srv == i_index) begin
            r_cnt[i_wr.layer] <= i_wr.cnt;
        end
    end

    always_comb begin
        w_cand = ({1'b0, i_index} < i_n) && ({1'b0, r_cnt[i_layer]} < {1'b0, i_max});
        w_take = 1'b0;
        priority if (i_policy == POL_FIRST) begin
            w_take = w_cand && !i_scan.found;
        end else if (i_policy == POL_RR) begin
            w_take = w_cand && (!i_scan.found ||
                     (i_scan.id < i_start && i_index >= i_start));
        end else begin
            w_take = w_cand && (!i_scan.found || r_cnt[i_layer] < i_scan.best);
        end
        n_scan = i_scan;
        if (w_take) begin
            n_scan.found = 1'b1;
            n_scan.id    = i_index;
            n_scan.best  = r_cnt[i_layer];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_scan.valid <= 1'b0;
        else          o_scan.valid <= i_scan.valid;
        o_scan.found <= n_scan.found;
        o_scan.id    <= n_scan.id;
        o_scan.best  <= n_scan.best;
    end
endmodule
